// ===== src/psg_pkg.sv =====
// shared types, constants and tables for the three-voice sound generator
// no dependencies
`default_nettype none
package psg_pkg;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  localparam logic [2:0] MODE_MONO = 3'd6;

  localparam logic [3:0] REG_MIXER   = 4'd7;
  localparam logic [3:0] REG_ENV_LO  = 4'd11;
  localparam logic [3:0] REG_ENV_HI  = 4'd12;
  localparam logic [3:0] REG_SHAPE   = 4'd13;
  localparam logic [3:0] REG_PORT_A  = 4'd14;
  localparam logic [3:0] REG_PORT_B  = 4'd15;

  localparam logic [15:0] FAST_LIMIT = 16'h0060;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input item, do bus part
    logic step;     // one internal step
    logic sub;      // subtract elapsed from phase
    logic mix;      // compute mix into output register
  } psg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic phase_neg;
    logic adv;
  } psg_stat_t;

  function automatic logic [7:0] reg_mask(input logic [3:0] r);
    case (r)
      4'd1, 4'd3, 4'd5, 4'd13: reg_mask = 8'h0f;
      4'd6, 4'd8, 4'd9, 4'd10: reg_mask = 8'h1f;
      default: reg_mask = 8'hff;
    endcase
  endfunction

  function automatic logic [13:0] dac(input logic [4:0] v);
    case (v[4:1])
      4'd0: dac = 14'h0000;
      4'd1: dac = 14'h00D0;
      4'd2: dac = 14'h0130;
      4'd3: dac = 14'h01BC;
      4'd4: dac = 14'h0291;
      4'd5: dac = 14'h03C4;
      4'd6: dac = 14'h0544;
      4'd7: dac = 14'h089F;
      4'd8: dac = 14'h0A27;
      4'd9: dac = 14'h1053;
      4'd10: dac = 14'h16C8;
      4'd11: dac = 14'h1C96;
      4'd12: dac = 14'h2417;
      4'd13: dac = 14'h2D54;
      4'd14: dac = 14'h35E8;
      default: dac = 14'h3FFF;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== src/psg_ctrl.sv =====
// controller state machine: sequences bus items, advance steps and mixing
// depends on psg_pkg
`default_nettype none
module psg_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire logic frozen,
  output psg_pkg::psg_cmd_t cmd,
  input  wire psg_pkg::psg_stat_t stat
);
  import psg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_LOOP = 3'd2;
  localparam logic [2:0] S_MIX  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state, state_next;
  logic acc;

  assign acc = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          cmd.load = 1'b1;
          state_next = S_SUB;
        end
      end
      S_SUB: begin
        if (stat.adv && !frozen) begin
          cmd.sub = 1'b1;
          state_next = S_LOOP;
        end else begin
          state_next = S_MIX;
        end
      end
      S_LOOP: begin
        if (stat.phase_neg) cmd.step = 1'b1;
        else state_next = S_MIX;
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.mix) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== src/psg_dp.sv =====
// datapath: register file, tone/noise/envelope generators and stereo mixer
// depends on psg_pkg
`default_nettype none
module psg_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire psg_pkg::psg_cmd_t cmd,
  output psg_pkg::psg_stat_t stat,
  input  wire logic [15:0] tick_period,
  input  wire logic [2:0] stereo_mode,
  input  wire logic [1:0] command,
  input  wire logic port_select,
  input  wire logic [7:0] value,
  input  wire logic [15:0] elapsed,
  output logic [7:0] read_data,
  output logic [14:0] left_sample,
  output logic [14:0] right_sample
);
  import psg_pkg::*;

  logic [3:0] sel;
  logic [7:0] regs [16];
  logic signed [17:0] phase;
  logic [15:0] el;
  logic [15:0] tper [3];
  logic [15:0] tcnt [3];
  logic [2:0] tlev;
  logic [9:0] nper, ncnt;
  logic [16:0] nsh;
  logic nlev;
  logic [19:0] eper, ecnt;
  logic signed [6:0] evol;
  logic signed [1:0] edir;
  logic [3:0] eshape;
  logic [4:0] vvol [3];
  logic [2:0] venv, tdis, ndis;
  logic adv;

  assign stat.phase_neg = phase[17];
  assign stat.adv = adv;

  logic [15:0] tcnt_inc [3];
  logic [9:0] ncnt_inc;
  logic [19:0] ecnt_inc;
  logic fb;
  logic signed [6:0] ev1, ev_n;
  logic signed [1:0] ed_n;
  logic [11:0] tp_raw;
  logic [15:0] ep_raw;
  logic [3:0] r;
  logic [7:0] rd_n;

  logic [14:0] vo [3];
  logic [14:0] lef, cen, rig;
  logic [16:0] sum3;
  logic [33:0] prod3;
  logic [14:0] avg;
  logic [13:0] env_lvl;

  assign r = sel;
  assign fb = ~(nsh[13] ^ nsh[16]);
  assign ev1 = evol + 7'(edir);
  assign env_lvl = dac(evol[4:0]);

  always_comb begin
    ev_n = ev1;
    ed_n = edir;
    if (ev1 < 0 || ev1 > 31) begin
      if (eshape[3]) begin
        if (eshape[0]) begin
          ev_n = evol;
          ed_n = 2'sd0;
          if (eshape[1]) ev_n = evol ^ 7'sd31;
        end else if (eshape[1]) begin
          ed_n = -edir;
          ev_n = ev1 - 7'(edir);
        end else begin
          ev_n = (ev1 < 0) ? 7'sd31 : 7'sd0;
        end
      end else begin
        ev_n = 7'sd0;
        ed_n = 2'sd0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) tcnt_inc[i] = tcnt[i] + 16'd1;
    ncnt_inc = ncnt + 10'd1;
    ecnt_inc = ecnt + 20'd1;
    if (r[0]) tp_raw = {value[3:0], regs[{r[3:1], 1'b0}]};
    else tp_raw = {regs[{r[3:1], 1'b1}][3:0], value};
    if (r == REG_ENV_LO) ep_raw = {regs[REG_ENV_HI], value};
    else ep_raw = {value, regs[REG_ENV_LO]};
    if (r == REG_PORT_A) rd_n = regs[REG_MIXER][6] ? 8'hff : regs[REG_PORT_A];
    else if (r == REG_PORT_B) rd_n = regs[REG_MIXER][7] ? 8'hff : regs[REG_PORT_B];
    else rd_n = regs[r] & reg_mask(r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
      for (int i = 0; i < 16; i++) regs[i] <= '0;
      phase <= '0;
      for (int i = 0; i < 3; i++) begin
        tper[i] <= '0;
        tcnt[i] <= '0;
        vvol[i] <= '0;
      end
      tlev <= '0; nper <= 10'd1; ncnt <= '0; nsh <= 17'h0ffff; nlev <= 1'b0;
      eper <= '0; ecnt <= '0; evol <= '0; edir <= '0; eshape <= '0;
      venv <= '0; tdis <= '0; ndis <= '0; adv <= 1'b0; read_data <= 8'hff;
    end else begin
      if (cmd.load) begin
        el <= elapsed;
        adv <= (command == CMD_ADVANCE);
        read_data <= (command == CMD_READ && port_select) ? rd_n : 8'hff;
        if (command == CMD_WRITE) begin
          if (port_select) sel <= value[3:0];
          else begin
            if (r != REG_PORT_A && r != REG_PORT_B) regs[r] <= value;
            case (r)
              4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5:
                tper[r[2:1]] <= {((tp_raw == 12'd0) ? 12'd1 : tp_raw), 4'h0};
              4'd6: nper <= {((value[4:0] == 5'd0) ? 5'd1 : value[4:0]), 5'd0};
              REG_MIXER: begin
                tdis <= value[2:0];
                ndis <= value[5:3];
              end
              4'd8, 4'd9, 4'd10: begin
                vvol[r[1:0]] <= {value[3:0], 1'b1};
                venv[r[1:0]] <= value[4];
              end
              REG_ENV_LO, REG_ENV_HI:
                eper <= {((ep_raw == 16'd0) ? 16'd1 : ep_raw), 4'h0};
              REG_SHAPE: begin
                eshape <= value[3:0];
                ecnt <= '0;
                evol <= value[2] ? 7'sd0 : 7'sd31;
                edir <= value[2] ? 2'sd1 : -2'sd1;
              end
              REG_PORT_A: if (regs[REG_MIXER][6]) regs[REG_PORT_A] <= value;
              REG_PORT_B: if (regs[REG_MIXER][7]) regs[REG_PORT_B] <= value;
              default: ;
            endcase
          end
        end
      end
      if (cmd.sub) phase <= phase - $signed({2'b00, el});
      if (cmd.step) begin
        phase <= phase + $signed({2'b00, tick_period});
        for (int i = 0; i < 3; i++) begin
          if (tcnt_inc[i] >= tper[i]) begin
            tcnt[i] <= '0;
            tlev[i] <= ~tlev[i];
          end else tcnt[i] <= tcnt_inc[i];
        end
        if (ncnt_inc >= nper) begin
          ncnt <= '0;
          nsh <= {nsh[15:0], fb};
          nlev <= nsh[15];
        end else ncnt <= ncnt_inc;
        if (ecnt_inc >= eper) begin
          ecnt <= '0;
          evol <= ev_n;
          edir <= ed_n;
        end else ecnt <= ecnt_inc;
      end
      if (cmd.mix) begin
        left_sample <= lef + {1'b0, cen[14:1]};
        right_sample <= rig + {1'b0, cen[14:1]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic m, f;
      m = (tdis[i] | tlev[i]) & (ndis[i] | nlev);
      f = tper[i] < FAST_LIMIT;
      vo[i] = '0;
      if (venv[i]) begin
        if (m) vo[i] = f ? {2'b0, env_lvl[13:1]} : {1'b0, env_lvl};
      end else if (f || m) vo[i] = {1'b0, dac(vvol[i])};
    end
    sum3 = {2'b0, vo[0]} + {2'b0, vo[1]} + {2'b0, vo[2]};
    prod3 = 34'(sum3) * 34'd43691;
    avg = prod3[31:17];
    case (stereo_mode)
      3'd0: begin lef = vo[0]; cen = vo[1]; rig = vo[2]; end
      3'd1: begin lef = vo[0]; cen = vo[2]; rig = vo[1]; end
      3'd2: begin lef = vo[1]; cen = vo[0]; rig = vo[2]; end
      3'd3: begin lef = vo[1]; cen = vo[2]; rig = vo[0]; end
      3'd4: begin lef = vo[2]; cen = vo[0]; rig = vo[1]; end
      3'd5: begin lef = vo[2]; cen = vo[1]; rig = vo[0]; end
      default: begin lef = avg; cen = avg; rig = avg; end
    endcase
  end
endmodule
`default_nettype wire

// ===== src/psg_three_voice_sound_generator_top.sv =====
// three-voice sound generator: bus write/read and time advance commands,
// one result transaction per input transaction carrying read byte and
// stereo mix. input and output use valid/ready; tick_period and
// stereo_mode come through a write port (index 0 and 1).
// a bus write or read passes through S_SUB and S_MIX from acceptance to output valid.
// an advance passes through S_SUB, then S_LOOP running one internal step per
// tick_period boundary crossed, then S_MIX; with
// tick_period zero it skips S_LOOP like a bus item.
// one transaction is in flight at a time; the next is accepted the cycle
// after the result is taken.
// while the receiver stalls the result holds.
// reset clears most registers (not the elapsed latch or the samples);
// stereo_mode becomes mono (6), noise shift register is loaded with 0xffff.
// depends on psg_pkg, psg_ctrl, psg_dp
`default_nettype none
module psg_three_voice_sound_generator_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] command,
  input  wire logic port_select,
  input  wire logic [7:0] value,
  input  wire logic [15:0] elapsed,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [7:0] read_data,
  output logic [14:0] left_sample,
  output logic [14:0] right_sample
);
  import psg_pkg::*;

  logic [15:0] tick_period;
  logic [2:0] stereo_mode;
  psg_cmd_t cmd;
  psg_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= '0;
      stereo_mode <= MODE_MONO;
    end else if (cfg_we) begin
      if (cfg_index) stereo_mode <= cfg_data[2:0];
      else tick_period <= cfg_data;
    end
  end

  psg_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .frozen(tick_period == 16'd0), .cmd, .stat
  );

  psg_dp u_dp (
    .clk, .rst, .cmd, .stat, .tick_period, .stereo_mode,
    .command, .port_select, .value, .elapsed,
    .read_data, .left_sample, .right_sample
  );
endmodule
`default_nettype wire
